// ----- design/hwdl_pkg.sv -----
// ----------------------------------------------------------------------------
// hwdl_pkg
// Shared constants, codes and types of the hashed word dictionary lookup unit.
// ----------------------------------------------------------------------------
package hwdl_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int HASH_W        = 32;
	localparam int OP_W          = 2;
	localparam int EIDX_W        = 8;
	localparam int BYTE_W        = 8;
	localparam int NEWEST_W      = 9;
	localparam int MIDX_W        = 9;

	localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;

	localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
	localparam logic [OP_W-1:0] OP_NAME   = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} scan_state_t;

	typedef struct packed {
		logic              start;
		logic              empty;
		logic [IDX_W-1:0]  top_idx;
		logic [HASH_W-1:0] key;
	} scan_cmd_t;

	typedef struct packed {
		logic              done;
		logic              busy;
		logic              found;
		logic [IDX_W-1:0]  idx;
		logic [HASH_W-1:0] key;
	} scan_res_t;

	// one FNV-1a fold step: xor the byte in, multiply by the prime mod 2^32
	function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
	                                               input logic [BYTE_W-1:0] b);
		logic [HASH_W-1:0] x;
		x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
		return HASH_W'(x * FNV_PRIME);
	endfunction

endpackage

// ----- design/hwdl_if.sv -----
// ----------------------------------------------------------------------------
// hwdl_req_if / hwdl_rsp_if
// Valid/ready channels for lookup unit requests and search results.
// ----------------------------------------------------------------------------
interface hwdl_req_if;
	import hwdl_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [EIDX_W-1:0] entry_index;
	logic [HASH_W-1:0] key_hash;
	logic [BYTE_W-1:0] name_byte;
	logic              last_byte;

	modport source (output valid, opcode, entry_index, key_hash, name_byte, last_byte,
	                input ready);
	modport sink   (input valid, opcode, entry_index, key_hash, name_byte, last_byte,
	                output ready);
endinterface

interface hwdl_rsp_if;
	import hwdl_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     found;
	logic signed [MIDX_W-1:0] match_index;
	logic [HASH_W-1:0]        name_hash;

	modport source (output valid, found, match_index, name_hash, input ready);
	modport sink   (input valid, found, match_index, name_hash, output ready);
endinterface

// ----- design/hwdl_ram.sv -----
// ----------------------------------------------------------------------------
// hwdl_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hwdl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- design/hwdl_hash.sv -----
// ----------------------------------------------------------------------------
// hwdl_hash
// Running FNV-1a name hash with end-of-name tracking.
// ----------------------------------------------------------------------------
module hwdl_hash (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      upd,
	input  logic [hwdl_pkg::BYTE_W-1:0] name_byte,
	input  logic                      last_byte,
	output logic [hwdl_pkg::HASH_W-1:0] hash_next
);
	import hwdl_pkg::*;

	logic [HASH_W-1:0] hash_q;
	logic              ended_q;
	logic              zero_byte;

	assign zero_byte = (name_byte == '0);
	assign hash_next = (ended_q || zero_byte) ? hash_q : fnv_fold(hash_q, name_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q  <= '0;
			ended_q <= 1'b0;
		end else if (upd) begin
			if (last_byte) begin
				hash_q  <= '0;
				ended_q <= 1'b0;
			end else begin
				hash_q  <= hash_next;
				ended_q <= ended_q | zero_byte;
			end
		end
	end
endmodule

// ----- design/hwdl_scan.sv -----
// ----------------------------------------------------------------------------
// hwdl_scan
// Search sequencer: walks table entries from the top index down, one RAM read
// per cycle, through a single shared compare unit.
// ----------------------------------------------------------------------------
module hwdl_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hwdl_pkg::scan_cmd_t         cmd,
	input  logic                        out_free,
	output logic                        rd_en,
	output logic [hwdl_pkg::IDX_W-1:0]  rd_addr,
	input  logic [hwdl_pkg::HASH_W-1:0] rd_data,
	output hwdl_pkg::scan_res_t         res
);
	import hwdl_pkg::*;

	scan_state_t       state_q, state_next;
	logic [HASH_W-1:0] key_q;
	logic [IDX_W-1:0]  addr_q;
	logic              issue_q;
	logic              cmp_vld_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic              found_q;
	logic [IDX_W-1:0]  idx_q;
	logic              hit;
	logic              finish;

	assign hit    = cmp_vld_s1 && (rd_data == key_q);
	assign finish = cmp_vld_s1 && (hit || cmp_idx_s1 == '0);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.start) begin
					state_next = cmd.empty ? S_DONE : S_SCAN;
				end
			end
			S_SCAN: begin
				if (finish) begin
					state_next = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_comb begin
		rd_en     = (state_q == S_SCAN) && issue_q;
		rd_addr   = addr_q;
		res.done  = (state_q == S_DONE) && out_free;
		res.busy  = (state_q != S_IDLE);
		res.found = found_q;
		res.idx   = idx_q;
		res.key   = key_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			issue_q    <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			state_q    <= state_next;
			cmp_vld_s1 <= rd_en && !finish;
			if (state_q == S_IDLE && cmd.start) begin
				issue_q <= !cmd.empty;
				found_q <= 1'b0;
			end else if (state_q == S_SCAN) begin
				if (finish || addr_q == '0) begin
					issue_q <= 1'b0;
				end
				if (hit) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd.start) begin
			key_q  <= cmd.key;
			addr_q <= cmd.top_idx;
		end else if (rd_en) begin
			addr_q <= addr_q - IDX_W'(1);
		end
		cmp_idx_s1 <= addr_q;
		if (hit) begin
			idx_q <= cmp_idx_s1;
		end
	end

`ifndef NO_ASSERTIONS
	// a scan in progress always has a read in flight or still to issue
	a_scan_live: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == S_SCAN && !issue_q && !cmp_vld_s1))
		else $error("scan stalled with nothing in flight");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> state_q == S_IDLE)
		else $error("search request while sequencer busy");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle after result");
`endif
endmodule

// ----- design/hashed_word_dictionary_lookup_unit.sv -----
// ----------------------------------------------------------------------------
// hashed_word_dictionary_lookup_unit
// Word hash table with FNV-1a name hashing and newest-first linear search.
//
//   channel  dir  handshake          payload
//   req      in   req.valid/ready    opcode, entry_index, key_hash, name_byte,
//                                    last_byte
//   rsp      out  rsp.valid/ready    found, match_index, name_hash
//   cfg      in   cfg_we             cfg_wdata (newest_entry)
//
// Writes and non-final name bytes start no search; the unit stays ready.
// A search reads entries from top (= clamped newest_entry) down, one table
// read per cycle through the single RAM read port and compare unit; an empty
// table goes straight to the done state. A pending result in the output
// register does not block new requests, but a finished search waits for it.
// Reset clears the hash state and sets newest_entry to -1; no clearing pass.
// ----------------------------------------------------------------------------
module hashed_word_dictionary_lookup_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	hwdl_req_if.sink                             req,
	hwdl_rsp_if.source                           rsp,
	input  logic                                 cfg_we,
	input  logic signed [hwdl_pkg::NEWEST_W-1:0] cfg_wdata
);
	import hwdl_pkg::*;

	logic signed [NEWEST_W-1:0] newest_q;
	logic                       accept;
	logic                       is_search;
	logic [HASH_W-1:0]          hash_next;
	scan_cmd_t                  cmd;
	scan_res_t                  res;
	logic                       out_free;
	logic                       ram_we;
	logic                       rd_en;
	logic [IDX_W-1:0]           rd_addr;
	logic [HASH_W-1:0]          rd_data;
	logic                       rsp_valid_q;
	logic                       rsp_found_q;
	logic signed [MIDX_W-1:0]   rsp_idx_q;
	logic [HASH_W-1:0]          rsp_hash_q;

	assign req.ready = !res.busy;
	assign accept    = req.valid && req.ready;
	assign is_search = (req.opcode == OP_LOOKUP) ||
	                   (req.opcode == OP_NAME && req.last_byte);

	assign ram_we = accept && (req.opcode == OP_WRITE) &&
	                ({1'b0, req.entry_index} < (EIDX_W+1)'(TABLE_ENTRIES));

	hwdl_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (accept && req.opcode == OP_NAME),
		.name_byte (req.name_byte),
		.last_byte (req.last_byte),
		.hash_next (hash_next)
	);

	// negative newest means empty; too large saturates to the last entry
	always_comb begin
		cmd.start = accept && is_search;
		cmd.empty = newest_q[NEWEST_W-1];
		cmd.key   = (req.opcode == OP_LOOKUP) ? req.key_hash : hash_next;
		if ($unsigned(newest_q) >= NEWEST_W'(TABLE_ENTRIES - 1)) begin
			cmd.top_idx = IDX_W'(TABLE_ENTRIES - 1);
		end else begin
			cmd.top_idx = newest_q[IDX_W-1:0];
		end
	end

	hwdl_ram #(
		.WIDTH (HASH_W),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (req.entry_index[IDX_W-1:0]),
		.wdata (req.key_hash),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	hwdl_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.out_free (out_free),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.res      (res)
	);

	assign out_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q    <= -NEWEST_W'(1);
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				newest_q <= cfg_wdata;
			end
			if (res.done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			rsp_found_q <= res.found;
			rsp_idx_q   <= res.found ? $signed({{(MIDX_W-IDX_W){1'b0}}, res.idx})
			                         : -MIDX_W'(1);
			rsp_hash_q  <= res.key;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = rsp_found_q;
	assign rsp.match_index = rsp_idx_q;
	assign rsp.name_hash   = rsp_hash_q;
endmodule
